// File: hdl/i2cms_pkg.sv
// shared types and constants for the i2c master transfer sequencer
// no dependencies; imported by i2cms_seq and the top level
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam int TX_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_SLA   = 3'd2,
    PH_TX    = 3'd3,
    PH_RX    = 3'd4,
    PH_STOP  = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_READ_ACK  = 3'd3,
    CMD_READ_NACK = 3'd4,
    CMD_STOP      = 3'd5
  } cmd_t;

  typedef struct packed {
    mode_t      mode;
    logic       engine_done;
    logic [7:0] engine_rx_byte;
    logic [3:0] load_index;
    logic [7:0] load_byte;
    logic [6:0] target_address;
    logic [7:0] transfer_length;
  } item_t;

  typedef struct packed {
    cmd_t       bus_command;
    logic [7:0] command_byte;
    logic       rx_valid;
    logic [7:0] rx_position;
    logic [7:0] rx_byte;
    logic       request_accepted;
    logic       busy_res;
    logic       rx_complete;
  } result_t;

endpackage

// File: hdl/i2cms_seq.sv
// transaction state, tx buffer and per-beat step logic of the sequencer
// depends on i2cms_pkg
`timescale 1ns / 1ps

module i2cms_seq
  import i2cms_pkg::*;
#(
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output result_t result
);

  localparam int CW = $clog2(TX_DEPTH + 1);
  localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  phase_t         phase_r, phase_nxt;
  logic [6:0]     sla_r, sla_nxt;
  logic           rnw_r, rnw_nxt;
  logic [CW-1:0]  tx_cnt_r, tx_cnt_nxt;
  logic [CW-1:0]  tx_pos_r, tx_pos_nxt;
  logic [7:0]     rx_cnt_r, rx_cnt_nxt;
  logic [7:0]     rx_pos_r, rx_pos_nxt;
  logic           rx_done_r, rx_done_nxt;
  logic [7:0]     tx_store [TX_DEPTH];

  logic           load_ok, len_ok, tx_more, rx_more, rx_last, load_we;
  logic [AW-1:0]  load_addr;
  logic [7:0]     tx_rd;

  assign load_ok   = 32'(item.load_index) < TX_DEPTH;
  assign len_ok    = 32'(item.transfer_length) <= TX_DEPTH;
  assign load_addr = AW'(item.load_index);
  assign tx_more   = (tx_pos_r < tx_cnt_r) && (32'(tx_pos_r) < TX_DEPTH);
  assign rx_more   = rx_pos_r < rx_cnt_r;
  assign rx_last   = (9'(rx_pos_r) + 9'd1) >= 9'(rx_cnt_r);
  assign tx_rd     = tx_store[tx_pos_r[AW-1:0]];
  assign load_we   = step && (item.mode == MODE_LOAD) && (phase_r == PH_IDLE) && load_ok;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      if (item.mode == MODE_TICK) begin
        case (phase_r)
          PH_START: phase_nxt = PH_SLA;
          PH_SLA:   if (item.engine_done) phase_nxt = rnw_r ? PH_RX : PH_TX;
          PH_TX:    if (item.engine_done && !tx_more) phase_nxt = PH_STOP;
          PH_RX:    if (item.engine_done && !rx_more) phase_nxt = PH_STOP;
          PH_STOP:  phase_nxt = PH_DONE;
          default:  phase_nxt = PH_IDLE;
        endcase
      end else if (phase_r == PH_IDLE) begin
        if ((item.mode == MODE_WRITE && len_ok) || (item.mode == MODE_READ && rx_done_r)) begin
          phase_nxt = PH_START;
        end
      end
    end
  end

  // result fields and datapath registers
  always_comb begin
    result      = '0;
    sla_nxt     = sla_r;
    rnw_nxt     = rnw_r;
    tx_cnt_nxt  = tx_cnt_r;
    tx_pos_nxt  = tx_pos_r;
    rx_cnt_nxt  = rx_cnt_r;
    rx_pos_nxt  = rx_pos_r;
    rx_done_nxt = rx_done_r;
    if (step) begin
      if (item.mode == MODE_TICK) begin
        case (phase_r)
          PH_START: result.bus_command = CMD_START;
          PH_SLA: begin
            if (item.engine_done) begin
              result.bus_command  = CMD_WRITE;
              result.command_byte = {sla_r, rnw_r};
            end
          end
          PH_TX: begin
            if (item.engine_done && tx_more) begin
              result.bus_command  = CMD_WRITE;
              result.command_byte = tx_rd;
              tx_pos_nxt          = tx_pos_r + CW'(1);
            end
          end
          PH_RX: begin
            if (item.engine_done) begin
              // byte finished by the engine belongs to the previous read
              if (rx_pos_r != 8'd0) begin
                result.rx_valid    = 1'b1;
                result.rx_position = rx_pos_r - 8'd1;
                result.rx_byte     = item.engine_rx_byte;
              end
              if (rx_more) begin
                result.bus_command = rx_last ? CMD_READ_NACK : CMD_READ_ACK;
                rx_pos_nxt         = rx_pos_r + 8'd1;
              end
            end
          end
          PH_STOP: result.bus_command = CMD_STOP;
          PH_DONE: rx_done_nxt = 1'b1;
          default: ;
        endcase
      end else if (phase_r == PH_IDLE) begin
        case (item.mode)
          MODE_LOAD: result.request_accepted = load_ok;
          MODE_WRITE: begin
            if (len_ok) begin
              sla_nxt    = item.target_address;
              rnw_nxt    = 1'b0;
              tx_cnt_nxt = CW'(item.transfer_length);
              tx_pos_nxt = '0;
              result.request_accepted = 1'b1;
            end
          end
          MODE_READ: begin
            if (rx_done_r) begin
              sla_nxt     = item.target_address;
              rnw_nxt     = 1'b1;
              rx_cnt_nxt  = item.transfer_length;
              rx_pos_nxt  = 8'd0;
              rx_done_nxt = 1'b1;
              result.request_accepted = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    result.busy_res    = (phase_nxt != PH_IDLE);
    result.rx_complete = rx_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      sla_r     <= '0;
      rnw_r     <= 1'b0;
      tx_cnt_r  <= '0;
      tx_pos_r  <= '0;
      rx_cnt_r  <= '0;
      rx_pos_r  <= '0;
      rx_done_r <= 1'b1;
    end else begin
      phase_r   <= phase_nxt;
      sla_r     <= sla_nxt;
      rnw_r     <= rnw_nxt;
      tx_cnt_r  <= tx_cnt_nxt;
      tx_pos_r  <= tx_pos_nxt;
      rx_cnt_r  <= rx_cnt_nxt;
      rx_pos_r  <= rx_pos_nxt;
      rx_done_r <= rx_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      tx_store[load_addr] <= item.load_byte;
    end
  end

endmodule

// File: hdl/i2c_master_transfer_sequencer.sv
// top level: input register, sequencer step and result register
// depends on i2cms_pkg and i2cms_seq
`timescale 1ns / 1ps

// Byte-level i2c master sequencer. Each input beat (tick, tx-buffer load,
// write or read request) yields exactly one result beat. A beat is captured
// in an input register, stepped through the sequencer state and held in the
// result register: one beat per cycle sustained while results are taken.
// The input register keeps taking a beat while a result waits to be taken;
// ready falls only when both registers are full and the result is stalled.
// The tx buffer is TX_DEPTH bytes of flip-flops with no reset; sending an
// entry never loaded gives an undefined byte.
module i2c_master_transfer_sequencer
  import i2cms_pkg::*;
#(
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic       in_engine_done,
  input  logic [7:0] in_engine_rx_byte,
  input  logic [3:0] in_load_index,
  input  logic [7:0] in_load_byte,
  input  logic [6:0] in_target_address,
  input  logic [7:0] in_transfer_length,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_bus_command,
  output logic [7:0] out_command_byte,
  output logic       out_rx_valid,
  output logic [7:0] out_rx_position,
  output logic [7:0] out_rx_byte,
  output logic       out_request_accepted,
  output logic       out_busy_res,
  output logic       out_rx_complete
);

  logic    in_full_r, in_full_nxt;
  item_t   in_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t step_res;
  logic    move;

  // beat moves from input register to result register
  assign move        = in_full_r && (!out_valid_r || out_ready);
  assign in_ready    = !in_full_r || move;
  assign in_full_nxt = (in_valid && in_ready) || (in_full_r && !move);
  assign out_valid_nxt = move || (out_valid_r && !out_ready);

  i2cms_seq #(
    .TX_DEPTH(TX_DEPTH)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (move),
    .item   (in_item_r),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.mode            <= mode_t'(in_mode);
      in_item_r.engine_done     <= in_engine_done;
      in_item_r.engine_rx_byte  <= in_engine_rx_byte;
      in_item_r.load_index      <= in_load_index;
      in_item_r.load_byte       <= in_load_byte;
      in_item_r.target_address  <= in_target_address;
      in_item_r.transfer_length <= in_transfer_length;
    end
    if (move) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_bus_command      = out_res_r.bus_command;
  assign out_command_byte     = out_res_r.command_byte;
  assign out_rx_valid         = out_res_r.rx_valid;
  assign out_rx_position      = out_res_r.rx_position;
  assign out_rx_byte          = out_res_r.rx_byte;
  assign out_request_accepted = out_res_r.request_accepted;
  assign out_busy_res         = out_res_r.busy_res;
  assign out_rx_complete      = out_res_r.rx_complete;

  // a delivered rx byte only comes with a read command or the move to stop
  a_rx_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rx_valid |->
      (out_bus_command == CMD_NONE || out_bus_command == CMD_READ_ACK ||
       out_bus_command == CMD_READ_NACK))
    else $error("rx byte delivered with unexpected bus command");

  // an accepted request or load never issues a bus command and leaves busy only for requests
  a_req_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request_accepted |-> out_bus_command == CMD_NONE)
    else $error("accepted request carries a bus command");

  // a stalled result keeps the input register from draining
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_full_r && out_valid && !out_ready |=> in_full_r && out_valid)
    else $error("beat lost while result stalled");

  // the read-complete flag is never cleared
  a_rxc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rx_complete)
    else $error("read-complete flag cleared");

endmodule
